// File: rtl/cdg_pkg.sv
// shared types and constants for the cd+g graphics decoder
// no dependencies; used by every module in rtl/
`default_nettype none

package cdg_pkg;

   localparam int SCREEN_W  = 300;
   localparam int SCREEN_H  = 216;
   localparam int TILE_W    = 6;
   localparam int TILE_H    = 12;
   localparam int PIX_DEPTH = SCREEN_W * SCREEN_H;
   localparam int ADDR_W    = $clog2(PIX_DEPTH);
   localparam int ROW_W     = 8;
   localparam int COL_W     = 9;
   localparam int TI_W      = $clog2(TILE_H);
   localparam int TJ_W      = $clog2(TILE_W);

   localparam logic [1:0] MODE_APPLY = 2'd0;
   localparam logic [1:0] MODE_READ  = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;

   localparam logic [5:0] GRAPHICS_CMD     = 6'd9;
   localparam logic [5:0] OP_MEM_PRESET    = 6'd1;
   localparam logic [5:0] OP_BORDER_PRESET = 6'd2;
   localparam logic [5:0] OP_TILE_SET      = 6'd6;
   localparam logic [5:0] OP_SCROLL_FILL   = 6'd20;
   localparam logic [5:0] OP_SCROLL_WRAP   = 6'd24;
   localparam logic [5:0] OP_ALPHA         = 6'd28;
   localparam logic [5:0] OP_TABLE_LOW     = 6'd30;
   localparam logic [5:0] OP_TABLE_HIGH    = 6'd31;
   localparam logic [5:0] OP_TILE_XOR      = 6'd38;

   localparam logic [1:0] SCROLL_NONE = 2'd0;
   localparam logic [1:0] SCROLL_FWD  = 2'd1;   // right or down
   localparam logic [1:0] SCROLL_BACK = 2'd2;   // left or up

   typedef enum logic [2:0] {
      JOB_NONE,
      JOB_READ,
      JOB_CLEAR,
      JOB_PRESET,
      JOB_BORDER,
      JOB_TILE,
      JOB_SCROLL
   } job_kind_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SWEEP,
      S_VSTEP,
      S_READ,
      S_RDWAIT,
      S_DONE
   } seq_state_type;

   typedef struct packed {
      job_kind_type                    kind;
      logic [ROW_W-1:0]                r_lo;
      logic [ROW_W-1:0]                r_hi;
      logic [COL_W-1:0]                c_lo;
      logic [COL_W-1:0]                c_hi;
      logic [3:0]                      value;
      logic [3:0]                      color0;
      logic [3:0]                      color1;
      logic [TILE_H-1:0][TILE_W-1:0]   bits;
      logic                            xor_mode;
      logic [1:0]                      hcmd;
      logic [1:0]                      vcmd;
      logic                            wrap;
   } seq_job_type;

   typedef struct packed {
      logic              wen;
      logic              ren;
      logic [ADDR_W-1:0] addr;
      logic [3:0]        wdata;
   } mem_req_type;

   typedef struct packed {
      logic idle;
      logic done;
   } seq_stat_type;

endpackage

`default_nettype wire

// File: rtl/cdg_pix_mem.sv
// pixel store: 64800 x 4-bit synchronous ram, one port, registered read
// depends on cdg_pkg
`default_nettype none

module cdg_pix_mem (
   input  wire logic                 clock,
   input  wire cdg_pkg::mem_req_type req,
   output logic [3:0]                rdata
);

   logic [3:0] pix_ram [0:cdg_pkg::PIX_DEPTH-1];
   logic [3:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (req.wen) begin
         pix_ram[req.addr] <= req.wdata;
      end
      if (req.ren) begin
         rdata_ff <= pix_ram[req.addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// File: rtl/cdg_seq.sv
// sweep sequencer: walks screen regions, maps logical rows/columns through
// the scroll bases onto ram addresses; depends on cdg_pkg
`default_nettype none

module cdg_seq (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire cdg_pkg::seq_job_type  job,
   input  wire logic [3:0]            rdata,
   output cdg_pkg::mem_req_type       mem_req,
   output cdg_pkg::seq_stat_type      stat
);

   localparam logic [cdg_pkg::ROW_W-1:0] LAST_ROW = cdg_pkg::ROW_W'(cdg_pkg::SCREEN_H - 1);
   localparam logic [cdg_pkg::COL_W-1:0] LAST_COL = cdg_pkg::COL_W'(cdg_pkg::SCREEN_W - 1);

   cdg_pkg::seq_state_type state_ff, state_in;
   cdg_pkg::seq_job_type   job_ff, job_in;
   cdg_pkg::seq_job_type   clear_job;
   logic [cdg_pkg::ROW_W-1:0] r_ff, r_in, vb_ff, vb_in;
   logic [cdg_pkg::COL_W-1:0] c_ff, c_in, hb_ff, hb_in;
   logic [cdg_pkg::TI_W-1:0]  ti_ff, ti_in;
   logic [cdg_pkg::TJ_W-1:0]  tj_ff, tj_in;
   logic phase_ff, phase_in, init_ff, init_in, vdone_ff, vdone_in;

   logic [cdg_pkg::ROW_W:0]   prow_sum;
   logic [cdg_pkg::COL_W:0]   pcol_sum;
   logic [cdg_pkg::ROW_W-1:0] prow;
   logic [cdg_pkg::COL_W-1:0] pcol;
   logic rd_phase, last_pix, in_border, h_fill, v_fill;
   logic [3:0] tile_v;
   logic [cdg_pkg::COL_W-1:0] hb_next;
   logic [cdg_pkg::ROW_W-1:0] vb_next;

   // job loaded at reset: clear the whole store
   always_comb begin
      clear_job      = '0;
      clear_job.kind = cdg_pkg::JOB_CLEAR;
      clear_job.r_hi = LAST_ROW;
      clear_job.c_hi = LAST_COL;
   end

   // logical to physical position through the scroll bases
   always_comb begin
      prow_sum = {1'b0, r_ff} + {1'b0, vb_ff};
      pcol_sum = {1'b0, c_ff} + {1'b0, hb_ff};
      prow = (prow_sum >= (cdg_pkg::ROW_W+1)'(cdg_pkg::SCREEN_H))
             ? cdg_pkg::ROW_W'(prow_sum - (cdg_pkg::ROW_W+1)'(cdg_pkg::SCREEN_H))
             : prow_sum[cdg_pkg::ROW_W-1:0];
      pcol = (pcol_sum >= (cdg_pkg::COL_W+1)'(cdg_pkg::SCREEN_W))
             ? cdg_pkg::COL_W'(pcol_sum - (cdg_pkg::COL_W+1)'(cdg_pkg::SCREEN_W))
             : pcol_sum[cdg_pkg::COL_W-1:0];
   end

   always_comb begin
      rd_phase  = job_ff.xor_mode && !phase_ff;
      last_pix  = (r_ff == job_ff.r_hi) && (c_ff == job_ff.c_hi);
      in_border = (r_ff < cdg_pkg::ROW_W'(cdg_pkg::TILE_H))
               || (r_ff >= cdg_pkg::ROW_W'(cdg_pkg::SCREEN_H - cdg_pkg::TILE_H))
               || (c_ff < cdg_pkg::COL_W'(cdg_pkg::TILE_W))
               || (c_ff >= cdg_pkg::COL_W'(cdg_pkg::SCREEN_W - cdg_pkg::TILE_W));
      tile_v = job_ff.bits[ti_ff][cdg_pkg::TJ_W'(cdg_pkg::TILE_W - 1) - tj_ff]
               ? job_ff.color1 : job_ff.color0;
      h_fill = !job.wrap && (job.hcmd == cdg_pkg::SCROLL_FWD
                             || job.hcmd == cdg_pkg::SCROLL_BACK);
      v_fill = !job_ff.wrap && (job_ff.vcmd == cdg_pkg::SCROLL_FWD
                                || job_ff.vcmd == cdg_pkg::SCROLL_BACK);
      // new bases move by one tile, modulo the screen size
      case (job.hcmd)
         cdg_pkg::SCROLL_FWD:
            hb_next = (hb_ff >= cdg_pkg::COL_W'(cdg_pkg::TILE_W))
                      ? hb_ff - cdg_pkg::COL_W'(cdg_pkg::TILE_W)
                      : hb_ff + cdg_pkg::COL_W'(cdg_pkg::SCREEN_W - cdg_pkg::TILE_W);
         cdg_pkg::SCROLL_BACK:
            hb_next = (hb_ff >= cdg_pkg::COL_W'(cdg_pkg::SCREEN_W - cdg_pkg::TILE_W))
                      ? hb_ff - cdg_pkg::COL_W'(cdg_pkg::SCREEN_W - cdg_pkg::TILE_W)
                      : hb_ff + cdg_pkg::COL_W'(cdg_pkg::TILE_W);
         default: hb_next = hb_ff;
      endcase
      case (job_ff.vcmd)
         cdg_pkg::SCROLL_FWD:
            vb_next = (vb_ff >= cdg_pkg::ROW_W'(cdg_pkg::TILE_H))
                      ? vb_ff - cdg_pkg::ROW_W'(cdg_pkg::TILE_H)
                      : vb_ff + cdg_pkg::ROW_W'(cdg_pkg::SCREEN_H - cdg_pkg::TILE_H);
         cdg_pkg::SCROLL_BACK:
            vb_next = (vb_ff >= cdg_pkg::ROW_W'(cdg_pkg::SCREEN_H - cdg_pkg::TILE_H))
                      ? vb_ff - cdg_pkg::ROW_W'(cdg_pkg::SCREEN_H - cdg_pkg::TILE_H)
                      : vb_ff + cdg_pkg::ROW_W'(cdg_pkg::TILE_H);
         default: vb_next = vb_ff;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cdg_pkg::S_IDLE: begin
            if (start) begin
               case (job.kind)
                  cdg_pkg::JOB_NONE:   state_in = cdg_pkg::S_DONE;
                  cdg_pkg::JOB_READ:   state_in = cdg_pkg::S_READ;
                  cdg_pkg::JOB_SCROLL: state_in = h_fill ? cdg_pkg::S_SWEEP
                                                         : cdg_pkg::S_VSTEP;
                  default:             state_in = cdg_pkg::S_SWEEP;
               endcase
            end
         end
         cdg_pkg::S_SWEEP: begin
            if (!rd_phase && last_pix) begin
               if (init_ff) begin
                  state_in = cdg_pkg::S_IDLE;
               end else if (job_ff.kind == cdg_pkg::JOB_SCROLL && !vdone_ff) begin
                  state_in = cdg_pkg::S_VSTEP;
               end else begin
                  state_in = cdg_pkg::S_DONE;
               end
            end
         end
         cdg_pkg::S_VSTEP:  state_in = v_fill ? cdg_pkg::S_SWEEP : cdg_pkg::S_DONE;
         cdg_pkg::S_READ:   state_in = cdg_pkg::S_RDWAIT;
         cdg_pkg::S_RDWAIT: state_in = cdg_pkg::S_IDLE;
         cdg_pkg::S_DONE:   state_in = cdg_pkg::S_IDLE;
         default:           state_in = cdg_pkg::S_IDLE;
      endcase
   end

   // counters, bases and job latch
   always_comb begin
      job_in   = job_ff;
      r_in     = r_ff;
      c_in     = c_ff;
      ti_in    = ti_ff;
      tj_in    = tj_ff;
      phase_in = phase_ff;
      hb_in    = hb_ff;
      vb_in    = vb_ff;
      init_in  = init_ff;
      vdone_in = vdone_ff;
      case (state_ff)
         cdg_pkg::S_IDLE: begin
            if (start) begin
               job_in   = job;
               ti_in    = '0;
               tj_in    = '0;
               phase_in = 1'b0;
               vdone_in = 1'b0;
               if (job.kind == cdg_pkg::JOB_SCROLL) begin
                  hb_in       = hb_next;
                  job_in.r_lo = '0;
                  job_in.r_hi = LAST_ROW;
                  job_in.c_lo = (job.hcmd == cdg_pkg::SCROLL_FWD) ? '0
                              : cdg_pkg::COL_W'(cdg_pkg::SCREEN_W - cdg_pkg::TILE_W);
                  job_in.c_hi = (job.hcmd == cdg_pkg::SCROLL_FWD)
                              ? cdg_pkg::COL_W'(cdg_pkg::TILE_W - 1) : LAST_COL;
               end
               r_in = job_in.r_lo;
               c_in = job_in.c_lo;
            end
         end
         cdg_pkg::S_SWEEP: begin
            if (rd_phase) begin
               phase_in = 1'b1;
            end else begin
               phase_in = 1'b0;
               if (last_pix) begin
                  init_in = 1'b0;
               end
               if (c_ff == job_ff.c_hi) begin
                  c_in  = job_ff.c_lo;
                  tj_in = '0;
                  r_in  = r_ff + 1'b1;
                  ti_in = ti_ff + 1'b1;
               end else begin
                  c_in  = c_ff + 1'b1;
                  tj_in = tj_ff + 1'b1;
               end
            end
         end
         cdg_pkg::S_VSTEP: begin
            vb_in       = vb_next;
            vdone_in    = 1'b1;
            job_in.r_lo = (job_ff.vcmd == cdg_pkg::SCROLL_FWD) ? '0
                        : cdg_pkg::ROW_W'(cdg_pkg::SCREEN_H - cdg_pkg::TILE_H);
            job_in.r_hi = (job_ff.vcmd == cdg_pkg::SCROLL_FWD)
                        ? cdg_pkg::ROW_W'(cdg_pkg::TILE_H - 1) : LAST_ROW;
            job_in.c_lo = '0;
            job_in.c_hi = LAST_COL;
            r_in        = job_in.r_lo;
            c_in        = '0;
         end
         default: begin
         end
      endcase
   end

   // memory port and status
   always_comb begin
      mem_req.wen   = 1'b0;
      mem_req.ren   = 1'b0;
      mem_req.addr  = cdg_pkg::ADDR_W'(prow) * cdg_pkg::ADDR_W'(cdg_pkg::SCREEN_W)
                    + cdg_pkg::ADDR_W'(pcol);
      mem_req.wdata = job_ff.value;
      case (state_ff)
         cdg_pkg::S_SWEEP: begin
            if (rd_phase) begin
               mem_req.ren = 1'b1;
            end else begin
               mem_req.wen = (job_ff.kind != cdg_pkg::JOB_BORDER) || in_border;
               if (job_ff.kind == cdg_pkg::JOB_TILE) begin
                  mem_req.wdata = job_ff.xor_mode ? (rdata ^ tile_v) : tile_v;
               end
            end
         end
         cdg_pkg::S_READ: mem_req.ren = 1'b1;
         default: begin
         end
      endcase
      stat.idle = (state_ff == cdg_pkg::S_IDLE);
      stat.done = (state_ff == cdg_pkg::S_DONE) || (state_ff == cdg_pkg::S_RDWAIT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         // clearing pass over the whole store after reset
         state_ff        <= cdg_pkg::S_SWEEP;
         init_ff         <= 1'b1;
         vdone_ff        <= 1'b0;
         phase_ff        <= 1'b0;
         hb_ff           <= '0;
         vb_ff           <= '0;
         r_ff            <= '0;
         c_ff            <= '0;
         ti_ff           <= '0;
         tj_ff           <= '0;
         job_ff          <= clear_job;
      end else begin
         state_ff <= state_in;
         init_ff  <= init_in;
         vdone_ff <= vdone_in;
         phase_ff <= phase_in;
         hb_ff    <= hb_in;
         vb_ff    <= vb_in;
         r_ff     <= r_in;
         c_ff     <= c_in;
         ti_ff    <= ti_in;
         tj_ff    <= tj_in;
         job_ff   <= job_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/cdg_graphics_decoder.sv
// top level of the cd+g graphics decoder: stream ports, packet decode,
// colour table and status registers; depends on cdg_pkg, cdg_seq, cdg_pix_mem
`default_nettype none

// usage
//   req_* carries one word per step: tuser is the mode (apply packet, read
//   pixel, clear), tdata the packet and the read position. rsp_* returns one
//   word per accepted request with the pixel read (zero unless reading), the
//   fine scroll offsets and the border and background indices.
// work per request on the single ram port, one pixel per cycle (tile xor
// reads each pixel before writing it)
//   no pixel written: no-op packets, colour loads, alpha clear, wrap scroll
//   pixel read: one pixel; tile set and xor: the tile; fill scroll: the
//   uncovered strips; memory preset: inside the border; border preset and
//   clear: a sweep over the whole store; scrolls move base pointers instead
//   of pixels, so only uncovered strips get written
// one request is worked on at a time; req_tready stays low until its response
// has entered the output register and that register is free
// reset: a clearing pass writes all 64800 pixels with req_tready low; border
// and background indices return to 255
// a stalled rsp_tready holds the response and blocks the next request

module cdg_graphics_decoder (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // command[5:0], instruction[11:6], data_low[75:12], data_high[139:76],
   // read_row[147:140], read_col[156:148], zero pad[159:157]
   input  wire logic [159:0] req_tdata,
   // mode[1:0]
   input  wire logic [1:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // pixel_index[7:0], pixel_color[23:8], h_offset[26:24], v_offset[30:27],
   // border_index[38:31], background_index[46:39], zero pad[47]
   output logic [47:0]       rsp_tdata
);

   function automatic logic [15:0] color_entry(input logic [7:0] hi_b, input logic [7:0] lo_b);
      return {4'hF, hi_b[5:2], hi_b[1:0], lo_b[5:4], lo_b[3:0]};
   endfunction

   // request fields
   logic [5:0]          command, instruction;
   logic [15:0][7:0]    pkt;
   logic [7:0]          read_row;
   logic [8:0]          read_col;
   logic [1:0]          mode;

   assign command     = req_tdata[5:0];
   assign instruction = req_tdata[11:6];
   assign pkt         = req_tdata[139:12];
   assign read_row    = req_tdata[147:140];
   assign read_col    = req_tdata[156:148];
   assign mode        = req_tuser;

   // state
   logic [7:0]  border_ff, border_in, bg_ff, bg_in;
   logic [2:0]  hoff_ff, hoff_in;
   logic [3:0]  voff_ff, voff_in;
   logic [15:0] ctab_ff [16];
   logic [15:0] ctab_in [16];
   logic        busy_ff, busy_in, rd_ff, rd_in, oos_ff, oos_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [47:0] rsp_data_ff, rsp_data_in;

   logic                  accept;
   cdg_pkg::seq_job_type  job;
   cdg_pkg::mem_req_type  mem_req;
   cdg_pkg::seq_stat_type stat;
   logic [3:0]            rdata;
   logic [8:0]            tile_top, tile_left;
   logic [7:0]            px_index;
   logic [15:0]           px_color;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = !busy_ff && stat.idle && (!rsp_valid_ff || rsp_tready);

   // tile placement in pixels
   assign tile_top  = {4'b0, pkt[2][4:0]} * 9'(cdg_pkg::TILE_H);
   assign tile_left = {3'b0, pkt[3][5:0]} * 9'(cdg_pkg::TILE_W);

   // packet decode
   always_comb begin
      job        = '0;
      job.kind   = cdg_pkg::JOB_NONE;
      border_in  = border_ff;
      bg_in      = bg_ff;
      hoff_in    = hoff_ff;
      voff_in    = voff_ff;
      ctab_in    = ctab_ff;
      rd_in      = rd_ff;
      oos_in     = oos_ff;
      for (int i = 0; i < cdg_pkg::TILE_H; i++) begin
         job.bits[i] = pkt[4 + i][5:0];
      end
      if (accept) begin
         rd_in  = (mode == cdg_pkg::MODE_READ);
         oos_in = (read_row >= 8'(cdg_pkg::SCREEN_H)) || (read_col >= 9'(cdg_pkg::SCREEN_W));
         case (mode)
            cdg_pkg::MODE_APPLY: begin
               if (command == cdg_pkg::GRAPHICS_CMD) begin
                  case (instruction)
                     cdg_pkg::OP_MEM_PRESET: begin
                        // a nonzero repeat count means the packet is a repeat
                        if (pkt[1][3:0] == 4'd0) begin
                           bg_in     = {4'd0, pkt[0][3:0]};
                           job.kind  = cdg_pkg::JOB_PRESET;
                           job.value = pkt[0][3:0];
                           job.r_lo  = 8'(cdg_pkg::TILE_H);
                           job.r_hi  = 8'(cdg_pkg::SCREEN_H - cdg_pkg::TILE_H - 1);
                           job.c_lo  = 9'(cdg_pkg::TILE_W);
                           job.c_hi  = 9'(cdg_pkg::SCREEN_W - cdg_pkg::TILE_W - 1);
                        end
                     end
                     cdg_pkg::OP_BORDER_PRESET: begin
                        border_in = {4'd0, pkt[0][3:0]};
                        job.kind  = cdg_pkg::JOB_BORDER;
                        job.value = pkt[0][3:0];
                        job.r_hi  = 8'(cdg_pkg::SCREEN_H - 1);
                        job.c_hi  = 9'(cdg_pkg::SCREEN_W - 1);
                     end
                     cdg_pkg::OP_TILE_SET, cdg_pkg::OP_TILE_XOR: begin
                        if (tile_top <= 9'(cdg_pkg::SCREEN_H - cdg_pkg::TILE_H)
                            && tile_left <= 9'(cdg_pkg::SCREEN_W - cdg_pkg::TILE_W)) begin
                           job.kind     = cdg_pkg::JOB_TILE;
                           job.xor_mode = (instruction == cdg_pkg::OP_TILE_XOR);
                           job.color0   = pkt[0][3:0];
                           job.color1   = pkt[1][3:0];
                           job.r_lo     = tile_top[7:0];
                           job.r_hi     = 8'(tile_top + 9'(cdg_pkg::TILE_H - 1));
                           job.c_lo     = tile_left;
                           job.c_hi     = tile_left + 9'(cdg_pkg::TILE_W - 1);
                        end
                     end
                     cdg_pkg::OP_SCROLL_FILL, cdg_pkg::OP_SCROLL_WRAP: begin
                        job.kind  = cdg_pkg::JOB_SCROLL;
                        job.value = pkt[0][3:0];
                        job.hcmd  = pkt[1][5:4];
                        job.vcmd  = pkt[2][5:4];
                        job.wrap  = (instruction == cdg_pkg::OP_SCROLL_WRAP);
                        hoff_in   = pkt[1][2:0];
                        voff_in   = pkt[2][3:0];
                     end
                     cdg_pkg::OP_ALPHA: begin
                        ctab_in[pkt[0][3:0]] = ctab_ff[pkt[0][3:0]] & 16'h0FFF;
                     end
                     cdg_pkg::OP_TABLE_LOW, cdg_pkg::OP_TABLE_HIGH: begin
                        for (int k = 0; k < 8; k++) begin
                           ctab_in[(instruction == cdg_pkg::OP_TABLE_HIGH) ? k + 8 : k] =
                              color_entry(pkt[2 * k], pkt[2 * k + 1]);
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            cdg_pkg::MODE_READ: begin
               if (!oos_in) begin
                  job.kind = cdg_pkg::JOB_READ;
                  job.r_lo = read_row;
                  job.c_lo = read_col;
               end
            end
            cdg_pkg::MODE_CLEAR: begin
               for (int k = 0; k < 16; k++) begin
                  ctab_in[k] = '0;
               end
               job.kind = cdg_pkg::JOB_CLEAR;
               job.r_hi = 8'(cdg_pkg::SCREEN_H - 1);
               job.c_hi = 9'(cdg_pkg::SCREEN_W - 1);
            end
            default: begin
            end
         endcase
      end
   end

   // response assembly
   always_comb begin
      px_index = '0;
      px_color = '0;
      if (rd_ff) begin
         px_index = oos_ff ? border_ff : {4'd0, rdata};
         px_color = (px_index[7:4] != 4'd0) ? 16'd0 : ctab_ff[px_index[3:0]];
      end
      busy_in      = busy_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         busy_in = 1'b1;
      end
      if (stat.done) begin
         busy_in      = 1'b0;
         rsp_valid_in = 1'b1;
         rsp_data_in  = {1'b0, bg_ff, border_ff, voff_ff, hoff_ff, px_color, px_index};
      end
   end

   cdg_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .start   (accept),
      .job     (job),
      .rdata   (rdata),
      .mem_req (mem_req),
      .stat    (stat)
   );

   cdg_pix_mem u_mem (
      .clock (clock),
      .req   (mem_req),
      .rdata (rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         border_ff    <= 8'hFF;
         bg_ff        <= 8'hFF;
         hoff_ff      <= '0;
         voff_ff      <= '0;
         busy_ff      <= 1'b0;
         rd_ff        <= 1'b0;
         oos_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < 16; k++) begin
            ctab_ff[k] <= '0;
         end
      end else begin
         border_ff    <= border_in;
         bg_ff        <= bg_in;
         hoff_ff      <= hoff_in;
         voff_ff      <= voff_in;
         busy_ff      <= busy_in;
         rd_ff        <= rd_in;
         oos_ff       <= oos_in;
         rsp_valid_ff <= rsp_valid_in;
         ctab_ff      <= ctab_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   a_start_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> !stat.idle) else $error("sequencer did not start on accept");
   a_done_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      stat.done |=> rsp_tvalid) else $error("finished item did not reach output");
   a_done_slot_free: assert property (@(posedge clock) disable iff (reset)
      stat.done |-> !rsp_tvalid) else $error("output register overwritten");
   a_busy_blocks: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !req_tready) else $error("request taken while busy");
`endif

endmodule

`default_nettype wire

// File: verif/cdg_graphics_decoder_tb.sv
// self-checking testbench for cdg_graphics_decoder: directed and random cd+g packets,
// pixel reads and clears with a scoreboard that predicts every response word
// depends on cdg_pkg and the rtl of cdg_graphics_decoder
`default_nettype none

// keeps its own copy of the screen, the colour table and the status registers
class cdg_screen_scoreboard;
   bit [3:0]  screen [0:215][0:299];
   bit [3:0]  shifted [0:215][0:299];
   bit [15:0] palette [0:15];
   bit [7:0]  border_idx;
   bit [7:0]  backgr_idx;
   bit [2:0]  fine_h;
   bit [3:0]  fine_v;
   bit [47:0] due_words [$];
   int        words_checked;
   int        mismatches;

   function new();
      foreach (screen[r, c]) screen[r][c] = 4'd0;
      foreach (palette[i]) palette[i] = 16'd0;
      border_idx = 8'hFF;
      backgr_idx = 8'hFF;
      fine_h = 3'd0;
      fine_v = 4'd0;
      words_checked = 0;
      mismatches = 0;
   endfunction

   function void fill_box(int r0, int r1, int c0, int c1, bit [3:0] v);
      for (int r = r0; r < r1; r++)
         for (int c = c0; c < c1; c++)
            screen[r][c] = v;
   endfunction

   // whole-screen shift by one tile; horizontal when horiz is set
   function void shift_screen(bit horiz, bit [1:0] dir, bit wrap, bit [3:0] fill);
      int sr;
      int sc;
      bit uncovered;
      foreach (screen[r, c]) begin
         sr = r;
         sc = c;
         uncovered = 1'b0;
         if (horiz && dir == cdg_pkg::SCROLL_FWD) begin
            sc = c - 6;
            if (c < 6) begin sc = c + 294; uncovered = 1'b1; end
         end else if (horiz) begin
            sc = c + 6;
            if (c >= 294) begin sc = c - 294; uncovered = 1'b1; end
         end else if (dir == cdg_pkg::SCROLL_FWD) begin
            sr = r - 12;
            if (r < 12) begin sr = r + 204; uncovered = 1'b1; end
         end else begin
            sr = r + 12;
            if (r >= 204) begin sr = r - 204; uncovered = 1'b1; end
         end
         shifted[r][c] = (uncovered && !wrap) ? fill : screen[sr][sc];
      end
      screen = shifted;
   endfunction

   // apply one accepted request word and queue the response it must produce
   function void note_request(bit [1:0] mode, bit [159:0] tdata);
      bit [5:0]   cmd;
      bit [5:0]   op;
      bit [127:0] pkt;
      bit [7:0]   row;
      bit [8:0]   col;
      bit [7:0]   idx;
      bit [15:0]  colour;
      bit [7:0]   b [0:15];
      int         top;
      int         left;
      bit [3:0]   v;
      bit [15:0]  w;
      bit [1:0]   hdir;
      bit [1:0]   vdir;
      cmd = tdata[5:0];
      op = tdata[11:6];
      pkt = tdata[139:12];
      row = tdata[147:140];
      col = tdata[156:148];
      idx = 8'd0;
      colour = 16'd0;
      for (int k = 0; k < 16; k++) b[k] = pkt[8*k +: 8];
      if (mode == cdg_pkg::MODE_APPLY && cmd == cdg_pkg::GRAPHICS_CMD) begin
         case (op)
            cdg_pkg::OP_MEM_PRESET: begin
               if (b[1][3:0] == 4'd0) begin
                  backgr_idx = {4'd0, b[0][3:0]};
                  fill_box(12, 204, 6, 294, b[0][3:0]);
               end
            end
            cdg_pkg::OP_BORDER_PRESET: begin
               border_idx = {4'd0, b[0][3:0]};
               fill_box(0, 216, 0, 6, b[0][3:0]);
               fill_box(0, 216, 294, 300, b[0][3:0]);
               fill_box(0, 12, 0, 300, b[0][3:0]);
               fill_box(204, 216, 0, 300, b[0][3:0]);
            end
            cdg_pkg::OP_TILE_SET, cdg_pkg::OP_TILE_XOR: begin
               top = b[2][4:0] * 12;
               left = b[3][5:0] * 6;
               if (top <= 204 && left <= 294)
                  for (int i = 0; i < 12; i++)
                     for (int j = 0; j < 6; j++) begin
                        v = b[4+i][5-j] ? b[1][3:0] : b[0][3:0];
                        if (op == cdg_pkg::OP_TILE_XOR)
                           screen[top+i][left+j] ^= v;
                        else
                           screen[top+i][left+j] = v;
                     end
            end
            cdg_pkg::OP_SCROLL_FILL, cdg_pkg::OP_SCROLL_WRAP: begin
               hdir = b[1][5:4];
               vdir = b[2][5:4];
               if (hdir == cdg_pkg::SCROLL_FWD || hdir == cdg_pkg::SCROLL_BACK)
                  shift_screen(1'b1, hdir, op == cdg_pkg::OP_SCROLL_WRAP, b[0][3:0]);
               if (vdir == cdg_pkg::SCROLL_FWD || vdir == cdg_pkg::SCROLL_BACK)
                  shift_screen(1'b0, vdir, op == cdg_pkg::OP_SCROLL_WRAP, b[0][3:0]);
               fine_h = b[1][2:0];
               fine_v = b[2][3:0];
            end
            cdg_pkg::OP_ALPHA: palette[b[0][3:0]] &= 16'h0FFF;
            cdg_pkg::OP_TABLE_LOW, cdg_pkg::OP_TABLE_HIGH: begin
               for (int k = 0; k < 8; k++) begin
                  w = {b[2*k+1], b[2*k]};
                  palette[(op == cdg_pkg::OP_TABLE_HIGH ? 8 : 0) + k] =
                     16'hF000 | ((w & 16'h003C) << 6) | ((w & 16'h0003) << 6)
                     | ((w & 16'h3000) >> 8) | ((w & 16'h0F00) >> 8);
               end
            end
            default: ;
         endcase
      end else if (mode == cdg_pkg::MODE_READ) begin
         idx = (row >= 216 || col >= 300) ? border_idx : {4'd0, screen[row][col]};
         colour = (idx[7:4] != 4'd0) ? 16'd0 : palette[idx[3:0]];
      end else if (mode == cdg_pkg::MODE_CLEAR) begin
         foreach (screen[r, c]) screen[r][c] = 4'd0;
         foreach (palette[i]) palette[i] = 16'd0;
      end
      due_words.push_back({1'b0, backgr_idx, border_idx, fine_v, fine_h, colour, idx});
   endfunction

   function void report(string field, bit [15:0] want, bit [15:0] got);
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      mismatches++;
   endfunction

   function void check_response(bit [47:0] got);
      bit [47:0] want;
      if (due_words.size() == 0) begin
         $display("%0t: unexpected response word %h", $time, got);
         mismatches++;
         return;
      end
      want = due_words.pop_front();
      words_checked++;
      if (want[7:0] != got[7:0]) report("pixel_index", want[7:0], got[7:0]);
      if (want[23:8] != got[23:8]) report("pixel_color", want[23:8], got[23:8]);
      if (want[26:24] != got[26:24]) report("h_offset", want[26:24], got[26:24]);
      if (want[30:27] != got[30:27]) report("v_offset", want[30:27], got[30:27]);
      if (want[38:31] != got[38:31]) report("border_index", want[38:31], got[38:31]);
      if (want[46:39] != got[46:39]) report("background_index", want[46:39], got[46:39]);
   endfunction
endclass

module cdg_graphics_decoder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cdg_pkg::*;

   // the mode value the block must treat as a no-op
   localparam logic [1:0] MODE_SPARE = 2'd3;
   localparam int CYCLE_LIMIT = 4_000_000;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [159:0] req_tdata;    // command, instruction, data_low, data_high, read_row, read_col
   logic [1:0]   req_tuser;    // mode
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [47:0]  rsp_tdata;    // pixel_index, pixel_color, h_offset, v_offset, border, background

   cdg_screen_scoreboard board;
   int  cycle_count;
   int  words_sent;
   bit  steady;       // no idling on either side while set
   bit  hold_rsp;     // asks the receiver for one long hold-off
   int  heavy_left;   // full-screen packets still allowed in the random part

   cdg_graphics_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog on total cycles
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("cdg_graphics_decoder test failed");
         $finish;
      end
   end

   // response monitor, values sampled as they stood at the edge
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_response(rsp_tdata);
   end

   // receiver: random stalls, mostly short, sometimes long, one forced hold-off
   initial begin
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (steady) begin
            rsp_tready <= 1'b1;
         end else if ($urandom_range(0, 49) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(20, 120)) @(posedge clock);
         end else begin
            rsp_tready <= ($urandom_range(0, 3) != 0);
         end
      end
   end

   // offer one word, wait for its handshake, then maybe leave a gap
   task automatic send_word(input logic [1:0] mode, input logic [5:0] cmd,
                            input logic [5:0] op, input logic [63:0] lo,
                            input logic [63:0] hi, input logic [7:0] row,
                            input logic [8:0] col);
      logic [159:0] word;
      int gap;
      word = {3'd0, col, row, hi, lo, op, cmd};
      req_tvalid <= 1'b1;
      req_tdata <= word;
      req_tuser <= mode;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(mode, word);
      words_sent++;
      gap = 0;
      if (!steady)
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_packet(input logic [5:0] op, input logic [63:0] lo,
                              input logic [63:0] hi);
      send_word(MODE_APPLY, GRAPHICS_CMD, op, lo, hi, 8'd0, 9'd0);
   endtask

   task automatic read_pixel(input logic [7:0] row, input logic [8:0] col);
      send_word(MODE_READ, 6'($urandom), 6'($urandom), {$urandom, $urandom},
                {$urandom, $urandom}, row, col);
   endtask

   // one random item, mostly well-formed graphics packets and reads
   task automatic random_item();
      logic [63:0] lo;
      logic [63:0] hi;
      logic [5:0]  op;
      int pick;
      lo = {$urandom, $urandom};
      hi = {$urandom, $urandom};
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         // keep most reads on screen, some anywhere
         if ($urandom_range(0, 3) == 0)
            read_pixel(8'($urandom), 9'($urandom));
         else
            read_pixel(8'($urandom_range(0, 215)), 9'($urandom_range(0, 299)));
         return;
      end
      if (pick < 34) begin
         send_word(MODE_SPARE, 6'($urandom), 6'($urandom), lo, hi, 8'($urandom),
                   9'($urandom));
         return;
      end
      if (pick < 38) begin
         send_word(MODE_APPLY, 6'($urandom), 6'($urandom), lo, hi, 8'($urandom),
                   9'($urandom));
         return;
      end
      if (pick < 45 && heavy_left > 0) begin
         heavy_left--;
         case ($urandom_range(0, 2))
            0: send_word(MODE_CLEAR, 6'($urandom), 6'($urandom), lo, hi, 8'($urandom),
                         9'($urandom));
            1: begin lo[15:8] = {4'($urandom), 4'd0}; send_packet(OP_MEM_PRESET, lo, hi); end
            default: send_packet(OP_BORDER_PRESET, lo, hi);
         endcase
         return;
      end
      case ($urandom_range(0, 7))
         0, 1: op = OP_TILE_SET;
         2, 3: op = OP_TILE_XOR;
         4:    op = ($urandom_range(0, 1) != 0) ? OP_SCROLL_WRAP : OP_SCROLL_FILL;
         5:    op = ($urandom_range(0, 1) != 0) ? OP_TABLE_LOW : OP_TABLE_HIGH;
         6:    op = OP_ALPHA;
         default: begin
            // a memory preset with a nonzero repeat count is ignored and cheap
            op = OP_MEM_PRESET;
            if (lo[11:8] == 4'd0) lo[8] = 1'b1;
         end
      endcase
      if (op == OP_TILE_SET || op == OP_TILE_XOR) begin
         if ($urandom_range(0, 7) != 0) begin
            lo[23:16] = {3'($urandom), 5'($urandom_range(0, 17))};
            lo[31:24] = {2'($urandom), 6'($urandom_range(0, 49))};
         end
      end
      send_packet(op, lo, hi);
   endtask

   initial begin
      board = new();
      cycle_count = 0;
      words_sent = 0;
      steady = 1'b0;
      hold_rsp = 1'b0;
      heavy_left = 2;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = MODE_APPLY;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: reset state, then each operation and corner
      read_pixel(8'd0, 9'd0);
      read_pixel(8'd255, 9'd511);                          // off screen, border index 255
      send_packet(OP_TABLE_LOW, 64'hFFFF_0000_3F3F_C0C0, 64'h1234_5678_9ABC_DEF0);
      send_packet(OP_TABLE_HIGH, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0000);
      send_packet(OP_ALPHA, 64'h0000_0000_0000_00F3, 64'd0);
      send_packet(OP_BORDER_PRESET, 64'h0000_0000_0000_00FA, 64'd0);
      send_packet(OP_MEM_PRESET, 64'h0000_0000_0000_0F05, 64'd0);   // repeat set, ignored
      send_packet(OP_MEM_PRESET, 64'h0000_0000_0000_F0F7, 64'd0);
      send_packet(OP_TILE_SET, 64'h2A15_0000_E011_0000, 64'hFFFF_FFFF_FFFF_FFFF);
      send_packet(OP_TILE_SET, 64'h3F00_FF31_F1F2, {8'h00, 56'hFF_00FF_00FF_00FF});
      send_packet(OP_TILE_XOR, 64'h1529_3105_0312, 64'h3F2A_1500_0102_0408);
      send_packet(OP_TILE_SET, 64'h3F00_0012_0F0E, 64'hFFFF_FFFF);  // row out of screen
      send_packet(OP_TILE_SET, 64'h3F00_3200_0F0E, 64'hFFFF_FFFF);  // column out of screen
      read_pixel(8'd215, 9'd299);
      read_pixel(8'd216, 9'd0);
      read_pixel(8'd0, 9'd300);
      send_packet(OP_SCROLL_FILL, 64'h0000_0000_001F_1F03, 64'd0);  // right and down, fill
      send_packet(OP_SCROLL_WRAP, 64'h0000_0000_002A_2105, 64'd0);  // left and up, wrap
      send_packet(OP_SCROLL_WRAP, 64'h0000_0000_0038_3700, 64'd0);  // no shift, offsets only
      read_pixel(8'd5, 9'd3);
      send_word(MODE_APPLY, 6'd63, OP_TILE_SET, '1, '1, 8'd0, 9'd0);  // not graphics
      send_packet(6'd63, '1, '1);                                     // unknown instruction
      send_word(MODE_SPARE, 6'd9, OP_BORDER_PRESET, '1, '1, '1, '1);
      send_word(MODE_CLEAR, '0, '0, '0, '0, '0, '0);
      read_pixel(8'd100, 9'd150);

      // random part, with a stretch free of idling and one long receiver hold-off
      for (int n = 0; n < 100; n++) begin
         steady = (n >= 40 && n < 55);
         if (n == 60) hold_rsp = 1'b1;
         random_item();
      end
      steady = 1'b0;
      req_tvalid <= 1'b0;

      while (board.due_words.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);

      $display("sent %0d request words, checked %0d response words in %0d cycles",
               words_sent, board.words_checked, cycle_count);
      if (board.mismatches == 0 && board.due_words.size() == 0)
         $display("cdg_graphics_decoder test passed");
      else
         $display("cdg_graphics_decoder test failed");
      $finish;
   end
endmodule

`default_nettype wire
